/* hw/rtl/hkvm_pkg.sv */
package hkvm_pkg;

    // map geometry
    localparam int BUCKETS = 64;
    localparam int WAYS    = 4;
    localparam int SLOTS   = BUCKETS * WAYS;

    // derived widths
    localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // word field widths
    localparam int OP_W    = 2;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int ECNT_W  = 9;
    localparam int ECNT_MAX = 511;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_GET    = 2'd0,
        OP_PUT    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // slot index of a way within a bucket
    function automatic logic [SLOT_W-1:0] slot_of(logic [BKT_W-1:0] bkt, logic [WAY_W-1:0] way);
        logic [31:0] idx;
        idx = 32'(bkt) * 32'(WAYS) + 32'(way);
        return idx[SLOT_W-1:0];
    endfunction

    // reported entry count saturates at the port maximum
    function automatic logic [ECNT_W-1:0] sat_count(logic [CNT_W-1:0] c);
        return (32'(c) > 32'(ECNT_MAX)) ? ECNT_W'(ECNT_MAX) : ECNT_W'(c);
    endfunction

endpackage

/* hw/rtl/hkvm_ram.sv */
module hkvm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/hashed_key_value_map.sv */
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+------------------------------------------
// input    | in        | in_valid / in_stall  | op, key, new_value
// output   | out       | out_valid / out_stall| found, value_out, full_res, entry_count
//
// get, put and remove scan the bucket one way at a time through a shared key compare:
// a ram read state and a compare state per way, stopping at a hit, then a write-back
// state and a result state before the next word is accepted.
// clear goes straight to the write-back state, where all valid bits drop together.
// reset clears the valid bits and the count at once; no clearing pass.
// a finished result waits in the output register, the next word is taken meanwhile.
module hashed_key_value_map (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [hkvm_pkg::OP_W-1:0]    op,
    input  logic [hkvm_pkg::KEY_W-1:0]   key,
    input  logic [hkvm_pkg::VAL_W-1:0]   new_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         found,
    output logic [hkvm_pkg::VAL_W-1:0]   value_out,
    output logic                         full_res,
    output logic [hkvm_pkg::ECNT_W-1:0]  entry_count
);

    import hkvm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_CMP  = 5'b00100,
        S_WR   = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VAL_W-1:0]    nv_reg, nv_next;
    logic [WAY_W-1:0]    way_reg, way_next;
    logic                hit_reg, hit_next;
    logic                free_reg, free_next;
    logic [SLOT_W-1:0]   tgt_reg, tgt_next;
    logic [VAL_W-1:0]    old_reg, old_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                res_found_reg, res_found_next;
    logic [VAL_W-1:0]    res_value_reg, res_value_next;
    logic                res_full_reg, res_full_next;
    logic [ECNT_W-1:0]   res_count_reg, res_count_next;
    logic                out_valid_reg, out_valid_next;
    logic                found_reg, found_next;
    logic [VAL_W-1:0]    value_reg, value_next;
    logic                full_reg, full_next;
    logic [ECNT_W-1:0]   count_reg, count_next;

    logic [BKT_W-1:0]         bucket;
    logic [SLOT_W-1:0]        cur_slot;
    logic                     ram_we;
    logic [KEY_W+VAL_W-1:0]   ram_rdata;
    logic [KEY_W-1:0]         rd_key;
    logic [VAL_W-1:0]         rd_val;
    logic                     way_valid;
    logic                     key_match;
    logic                     in_take;
    logic                     out_free;

    // bucket is the key modulo the bucket count
    assign bucket    = BKT_W'(key_reg % BUCKETS);
    assign cur_slot  = slot_of(bucket, way_reg);
    assign rd_key    = ram_rdata[KEY_W+VAL_W-1:VAL_W];
    assign rd_val    = ram_rdata[VAL_W-1:0];
    assign way_valid = valid_reg[cur_slot];
    assign key_match = way_valid && (rd_key == key_reg);

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // key and value store
    hkvm_ram #(
        .WIDTH (KEY_W + VAL_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tgt_reg),
        .wdata ({key_reg, nv_reg}),
        .raddr (cur_slot),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        nv_next        = nv_reg;
        way_next       = way_reg;
        hit_next       = hit_reg;
        free_next      = free_reg;
        tgt_next       = tgt_reg;
        old_next       = old_reg;
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        res_found_next = res_found_reg;
        res_value_next = res_value_reg;
        res_full_next  = res_full_reg;
        res_count_next = res_count_reg;
        ram_we         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    op_next    = op;
                    key_next   = key;
                    nv_next    = new_value;
                    way_next   = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    state_next = (op == OP_CLEAR) ? S_WR : S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (key_match)
                begin
                    hit_next   = 1'b1;
                    tgt_next   = cur_slot;
                    old_next   = rd_val;
                    state_next = S_WR;
                end
                else
                begin
                    // remember the lowest free way
                    if (!way_valid && !free_reg)
                    begin
                        free_next = 1'b1;
                        tgt_next  = cur_slot;
                    end
                    if (way_reg == WAY_W'(WAYS - 1))
                    begin
                        state_next = S_WR;
                    end
                    else
                    begin
                        way_next   = way_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_WR:
            begin
                res_found_next = 1'b0;
                res_value_next = '0;
                res_full_next  = 1'b0;
                if (op_reg == OP_CLEAR)
                begin
                    valid_next = '0;
                    cnt_next   = '0;
                end
                else if (hit_reg)
                begin
                    res_found_next = 1'b1;
                    res_value_next = old_reg;
                    if (op_reg == OP_PUT)
                    begin
                        ram_we = 1'b1;
                    end
                    else if (op_reg == OP_REMOVE)
                    begin
                        valid_next[tgt_reg] = 1'b0;
                        cnt_next            = cnt_reg - 1'b1;
                    end
                end
                else if (op_reg == OP_PUT)
                begin
                    if (free_reg)
                    begin
                        ram_we              = 1'b1;
                        valid_next[tgt_reg] = 1'b1;
                        cnt_next            = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        res_full_next = 1'b1;
                    end
                end
                res_count_next = sat_count(cnt_next);
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        value_next     = value_reg;
        full_next      = full_reg;
        count_next     = count_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_valid_next = 1'b1;
            found_next     = res_found_reg;
            value_next     = res_value_reg;
            full_next      = res_full_reg;
            count_next     = res_count_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result words
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        nv_reg        <= nv_next;
        way_reg       <= way_next;
        hit_reg       <= hit_next;
        free_reg      <= free_next;
        tgt_reg       <= tgt_next;
        old_reg       <= old_next;
        res_found_reg <= res_found_next;
        res_value_reg <= res_value_next;
        res_full_reg  <= res_full_next;
        res_count_reg <= res_count_next;
        found_reg     <= found_next;
        value_reg     <= value_next;
        full_reg      <= full_next;
        count_reg     <= count_next;
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign value_out   = value_reg;
    assign full_res    = full_reg;
    assign entry_count = count_reg;

    // count always matches the valid bits
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) == $countones(valid_reg))
        else $error("entry count differs from valid bits");

    // a clear leaves no valid entry
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR && op_reg == OP_CLEAR) |=> (valid_reg == '0))
        else $error("clear left valid entries");

    // one operation moves the count by at most one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR && op_reg != OP_CLEAR) |=>
            (cnt_reg == $past(cnt_reg) || cnt_reg == $past(cnt_reg) + 1'b1 ||
             cnt_reg + 1'b1 == $past(cnt_reg)))
        else $error("count moved by more than one");

    // a refused put never reports a hit, and a miss returns zero
    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!(found_reg && full_reg) && (found_reg || value_reg == '0)))
        else $error("inconsistent result flags");

endmodule
